[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL tree.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, initial hash values, round constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    localparam int WordW   = 32;
    localparam int LenW    = 61;
    localparam int Rounds  = 64;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    typedef struct packed {
        logic [WordW-1:0] word;
        logic             last_blk;
    } q_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PAD80,
        F_ZERO,
        F_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD,
        C_OUT
    } core_state_t;

    function automatic logic [WordW-1:0] iv_word(input logic [2:0] i);
        logic [WordW-1:0] v;
        case (i)
            3'd0:    v = 32'h6A09E667;
            3'd1:    v = 32'hBB67AE85;
            3'd2:    v = 32'h3C6EF372;
            3'd3:    v = 32'hA54FF53A;
            3'd4:    v = 32'h510E527F;
            3'd5:    v = 32'h9B05688C;
            3'd6:    v = 32'h1F83D9AB;
            3'd7:    v = 32'h5BE0CD19;
            default: v = 32'h6A09E667;
        endcase
        return v;
    endfunction

    function automatic logic [WordW-1:0] round_k(input logic [5:0] i);
        logic [WordW-1:0] k;
        case (i)
            6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF; 6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98; 6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h428A2F98;
        endcase
        return k;
    endfunction

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

`default_nettype wire

[rtl/core/sha_fifo.sv]
// ----------------------------------------------------------------------------
// SHA word queue
// Small register queue of schedule words between front and core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sha_pkg::q_entry_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   q_valid,
    output sha_pkg::q_entry_t      q_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha_pkg::q_entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sha_front.sv]
// ----------------------------------------------------------------------------
// SHA front end
// Accepts message bytes, packs them into words and inserts the padding.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   data_byte,
    input  wire logic         byte_present,
    input  wire logic         end_of_message,
    output logic              push,
    output sha_pkg::q_entry_t push_data,
    input  wire logic         full
);

    sha_pkg::front_state_t state_reg, state_next;
    logic [23:0]              word_reg;
    logic [5:0]               pos_reg;
    logic [5:0]               pos_inc;
    logic [2:0]               len_cnt_reg;
    logic [sha_pkg::LenW-1:0] len_reg;
    logic [63:0]              len_bits;
    logic                     accept;
    logic                     byte_req;
    logic [7:0]               byte_val;
    logic                     emit;

    assign in_stall = (state_reg != sha_pkg::F_IDLE) || full;
    assign accept   = in_valid && !in_stall;
    assign pos_inc  = pos_reg + 6'd1;
    assign len_bits = {len_reg, 3'b000};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::F_IDLE:
            begin
                if (accept && end_of_message)
                begin
                    state_next = sha_pkg::F_PAD80;
                end
            end
            sha_pkg::F_PAD80:
            begin
                if (emit)
                begin
                    state_next = (pos_inc == sha_pkg::LenPos) ? sha_pkg::F_LEN
                                                              : sha_pkg::F_ZERO;
                end
            end
            sha_pkg::F_ZERO:
            begin
                if (emit && pos_inc == sha_pkg::LenPos)
                begin
                    state_next = sha_pkg::F_LEN;
                end
            end
            sha_pkg::F_LEN:
            begin
                if (emit && len_cnt_reg == 3'd7)
                begin
                    state_next = sha_pkg::F_IDLE;
                end
            end
            default: state_next = sha_pkg::F_IDLE;
        endcase
    end

    // byte source
    always_comb
    begin
        byte_req = 1'b0;
        byte_val = 8'h00;
        case (state_reg)
            sha_pkg::F_IDLE:
            begin
                byte_req = accept && byte_present;
                byte_val = data_byte;
            end
            sha_pkg::F_PAD80:
            begin
                byte_req = 1'b1;
                byte_val = sha_pkg::PadByte;
            end
            sha_pkg::F_ZERO:
            begin
                byte_req = 1'b1;
            end
            sha_pkg::F_LEN:
            begin
                byte_req = 1'b1;
                byte_val = len_bits[{~len_cnt_reg, 3'b000} +: 8];
            end
            default:
            begin
                byte_req = 1'b0;
            end
        endcase
    end

    assign emit      = byte_req && !full;
    assign push      = emit && (pos_reg[1:0] == 2'd3);
    assign push_data = '{word: {word_reg, byte_val},
                         last_blk: (state_reg == sha_pkg::F_LEN) && (len_cnt_reg == 3'd7)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha_pkg::F_IDLE;
            pos_reg     <= '0;
            len_cnt_reg <= '0;
            len_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                pos_reg <= pos_inc;
            end
            if (state_reg == sha_pkg::F_LEN && emit)
            begin
                len_cnt_reg <= len_cnt_reg + 3'd1;
            end
            // drop the length once the closing word is out
            if (push_data.last_blk && emit)
            begin
                len_reg <= '0;
            end
            else if (accept && byte_present)
            begin
                len_reg <= len_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg <= {word_reg[15:0], byte_val};
        end
    end

endmodule

`default_nettype wire

[rtl/core/sha_core.sv]
// ----------------------------------------------------------------------------
// SHA compression core
// One round per cycle when fed, rolling schedule window, then digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire sha_pkg::q_entry_t q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [31:0]            digest_word,
    output logic [2:0]             word_index,
    output logic                   last_word
);

    sha_pkg::core_state_t state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] var_reg  [8];
    logic [31:0] win_reg  [16];
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        last_blk_reg;
    logic        in_load;
    logic        step;
    logic        out_xfer;
    logic [31:0] w_new, w_cur, s0, s1, t1, t2, a, e;

    assign in_load  = (round_reg[5:4] == 2'b00);
    assign out_xfer = out_valid && !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::C_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = sha_pkg::C_ROUND;
                end
            end
            sha_pkg::C_ROUND:
            begin
                if (step && round_reg == 6'd63)
                begin
                    state_next = sha_pkg::C_ADD;
                end
            end
            sha_pkg::C_ADD:
            begin
                state_next = last_blk_reg ? sha_pkg::C_OUT : sha_pkg::C_IDLE;
            end
            sha_pkg::C_OUT:
            begin
                if (out_xfer && idx_reg == 3'd7)
                begin
                    state_next = sha_pkg::C_IDLE;
                end
            end
            default: state_next = sha_pkg::C_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        step      = 1'b0;
        pop       = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            sha_pkg::C_ROUND:
            begin
                step = !in_load || q_valid;
                pop  = in_load && q_valid;
            end
            sha_pkg::C_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                step = 1'b0;
            end
        endcase
    end

    assign digest_word = hash_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    // round datapath
    always_comb
    begin
        s0 = sha_pkg::rotr(win_reg[1], 7) ^ sha_pkg::rotr(win_reg[1], 18)
           ^ (win_reg[1] >> 3);
        s1 = sha_pkg::rotr(win_reg[14], 17) ^ sha_pkg::rotr(win_reg[14], 19)
           ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
        w_cur = in_load ? q_data.word : w_new;
        a  = var_reg[0];
        e  = var_reg[4];
        t1 = var_reg[7]
           + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
           + ((e & var_reg[5]) ^ (~e & var_reg[6]))
           + sha_pkg::round_k(round_reg) + w_cur;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
           + ((a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha_pkg::C_IDLE;
            round_reg    <= '0;
            idx_reg      <= '0;
            last_blk_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::iv_word(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (step)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (pop)
            begin
                last_blk_reg <= q_data.last_blk;
            end
            if (state_reg == sha_pkg::C_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
                end
            end
            if (out_xfer)
            begin
                idx_reg <= idx_reg + 3'd1;
                // restore the initial values after the last word
                if (idx_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= sha_pkg::iv_word(3'(i));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sha_pkg::C_IDLE)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= hash_reg[i];
            end
        end
        else if (step)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= e;
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= a;
            var_reg[0] <= t1 + t2;
        end
        if (step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_cur;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sha256_message_hasher.sv]
// Streams a message one byte per transfer and returns its SHA-256 digest as
// eight 32-bit words, index 0 first, after the message's closing transfer.
// The front end takes at most one byte per cycle and packs words into a
// four-word queue; the compression core runs one round per cycle when it is
// not waiting on the queue. The first 16 rounds of a block consume queued
// words and so wait on the front end, which delivers one word per four bytes;
// 48 expansion rounds, a hash update step and a setup step follow. On a long
// message fed every cycle, throughput is therefore set by the byte rate
// during the load rounds plus the expansion rounds; input stalls whenever the
// queue is full. After the closing transfer the front end inserts the padding
// at one byte per cycle while the queue is not full; input stalls during the
// padding. Digest words then leave one per cycle when not stalled; new
// message bytes may be taken meanwhile until the queue fills.
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Top level: front end, word queue and compression core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sha256_message_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    logic              out_xfer;
    sha_pkg::q_entry_t push_data;
    sha_pkg::q_entry_t q_data;

    assign out_xfer = out_valid && !out_stall;

    sha_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .push           (push),
        .push_data      (push_data),
        .full           (full)
    );

    sha_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    `ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
    `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, q_valid, "pop from empty queue")
    `ASSERT_NEXT(a_digest_run, clk, rst_n, out_xfer && !last_word, out_valid, "digest run broken")
    `ASSERT_NEXT(a_digest_end, clk, rst_n, out_xfer && last_word, !out_valid, "extra digest word")

endmodule

`default_nettype wire
